// ----- sv/hpm_pkg.sv -----
// ----------------------------------------------------------------------------
// hpm_pkg
// shared widths, register indexes and divider control type of the point map core
// ----------------------------------------------------------------------------
`default_nettype none

package hpm_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned SumW     = 66;
  localparam int unsigned MagW     = 65;
  localparam int unsigned NumW     = MagW + 16;
  localparam int unsigned QuotW    = 32;

  localparam logic [CfgIdxW-1:0] RegCoef0 = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCoef1 = 8'd1;
  localparam logic [CfgIdxW-1:0] RegCoef2 = 8'd2;
  localparam logic [CfgIdxW-1:0] RegCoef3 = 8'd3;
  localparam logic [CfgIdxW-1:0] RegCoef4 = 8'd4;

  typedef struct packed {
    logic valid;
    logic zero;
    logic ovf_x;
    logic ovf_y;
    logic neg_x;
    logic neg_y;
  } div_ctl_t;

endpackage

`default_nettype wire

// ----- sv/homography_point_map_core.sv -----
// ----------------------------------------------------------------------------
// homography_point_map_core
// maps a Q16.16 point through a 3x3 Q12.20 homography, x/w and y/w rounded
// ----------------------------------------------------------------------------
// from start to done: capture, products, sums, divider setup, divider stages, output register
// throughput: one item per cycle, busy_o never rises
// the 32 quotient bits come from a chain of one-bit restoring divider stages
// reset: valid bits cleared, coefficients zero, no item in flight
`default_nettype none

module homography_point_map_core import hpm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic signed [CoordW-1:0] in_x_i,
  input  wire logic signed [CoordW-1:0] in_y_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic                     zero_weight_o,
  output logic                     saturated_o
);

  logic [CfgDataW-1:0] cw0_q, cw1_q, cw2_q, cw3_q;
  logic [CoefW-1:0]    cw4_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw0_q <= '0;
      cw1_q <= '0;
      cw2_q <= '0;
      cw3_q <= '0;
      cw4_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCoef0: cw0_q <= cfg_data_i;
        RegCoef1: cw1_q <= cfg_data_i;
        RegCoef2: cw2_q <= cfg_data_i;
        RegCoef3: cw3_q <= cfg_data_i;
        RegCoef4: cw4_q <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CoefW-1:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;
  assign e0 = cw0_q[31:0];
  assign e1 = cw0_q[63:32];
  assign e2 = cw1_q[31:0];
  assign e3 = cw1_q[63:32];
  assign e4 = cw2_q[31:0];
  assign e5 = cw2_q[63:32];
  assign e6 = cw3_q[31:0];
  assign e7 = cw3_q[63:32];
  assign e8 = cw4_q;

  // stage 1: capture
  logic                     v1_q;
  logic signed [CoordW-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    px_q <= in_x_i;
    py_q <= in_y_i;
  end

  // stage 2: products
  logic                    v2_q;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    p0_q <= px_q * e0;
    p1_q <= px_q * e1;
    p2_q <= px_q * e2;
    p3_q <= py_q * e3;
    p4_q <= py_q * e4;
    p5_q <= py_q * e5;
  end

  // stage 3: sums and magnitudes
  logic signed [SumW-1:0] sx, sy, sw;
  logic signed [SumW-1:0] nsx, nsy, nsw;
  assign sx = SumW'(p0_q) + SumW'(p3_q) + $signed({{18{e6[31]}}, e6, 16'b0});
  assign sy = SumW'(p1_q) + SumW'(p4_q) + $signed({{18{e7[31]}}, e7, 16'b0});
  assign sw = SumW'(p2_q) + SumW'(p5_q) + $signed({{18{e8[31]}}, e8, 16'b0});
  assign nsx = -sx;
  assign nsy = -sy;
  assign nsw = -sw;

  logic            v3_q, zero3_q, nx3_q, ny3_q, nw3_q;
  logic [MagW-1:0] mx3_q, my3_q, mw3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    zero3_q <= (sw == '0);
    nx3_q   <= sx[SumW-1];
    ny3_q   <= sy[SumW-1];
    nw3_q   <= sw[SumW-1];
    mx3_q   <= sx[SumW-1] ? nsx[MagW-1:0] : sx[MagW-1:0];
    my3_q   <= sy[SumW-1] ? nsy[MagW-1:0] : sy[MagW-1:0];
    mw3_q   <= sw[SumW-1] ? nsw[MagW-1:0] : sw[MagW-1:0];
  end

  // stage 4: overflow check and divider setup
  logic [NumW-1:0]     numx, numy;
  logic [NumW+15:0]    dsh;
  assign numx = {mx3_q, 16'b0};
  assign numy = {my3_q, 16'b0};
  assign dsh  = {mw3_q, 32'b0};

  div_ctl_t        ctl_q [0:QuotW];
  logic [MagW-1:0] d_q   [0:QuotW];
  logic [MagW-1:0] rx_q  [0:QuotW];
  logic [MagW-1:0] ry_q  [0:QuotW];
  logic [QuotW-1:0] lx_q [0:QuotW];
  logic [QuotW-1:0] ly_q [0:QuotW];
  logic [QuotW-1:0] qx_q [0:QuotW];
  logic [QuotW-1:0] qy_q [0:QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= '{valid: v3_q,
                    zero:  zero3_q,
                    ovf_x: {16'b0, numx} >= dsh,
                    ovf_y: {16'b0, numy} >= dsh,
                    neg_x: nx3_q ^ nw3_q,
                    neg_y: ny3_q ^ nw3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0]  <= mw3_q;
    rx_q[0] <= {16'b0, numx[NumW-1:32]};
    ry_q[0] <= {16'b0, numy[NumW-1:32]};
    lx_q[0] <= numx[31:0];
    ly_q[0] <= numy[31:0];
    qx_q[0] <= '0;
    qy_q[0] <= '0;
  end

  // divider stages, one quotient bit each
  for (genvar k = 0; k < QuotW; k++) begin : g_div
    logic [MagW:0] tx, ty;
    logic          gx, gy;
    assign tx = {rx_q[k], lx_q[k][QuotW-1]};
    assign ty = {ry_q[k], ly_q[k][QuotW-1]};
    assign gx = tx >= {1'b0, d_q[k]};
    assign gy = ty >= {1'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ctl_q[k+1] <= '0;
      else         ctl_q[k+1] <= ctl_q[k];
    end

    always_ff @(posedge clk_i) begin
      d_q[k+1]  <= d_q[k];
      rx_q[k+1] <= gx ? MagW'(tx - {1'b0, d_q[k]}) : tx[MagW-1:0];
      ry_q[k+1] <= gy ? MagW'(ty - {1'b0, d_q[k]}) : ty[MagW-1:0];
      lx_q[k+1] <= {lx_q[k][QuotW-2:0], 1'b0};
      ly_q[k+1] <= {ly_q[k][QuotW-2:0], 1'b0};
      qx_q[k+1] <= {qx_q[k][QuotW-2:0], gx};
      qy_q[k+1] <= {qy_q[k][QuotW-2:0], gy};
    end
  end

  // final stage: rounding, sign and clamp
  div_ctl_t        cf;
  logic [MagW-1:0] df;
  logic [QuotW:0]  qrx, qry;
  logic            sat_x, sat_y;
  logic [QuotW-1:0] vx, vy;
  localparam logic [QuotW:0] PosMax = 33'h0_7FFF_FFFF;
  localparam logic [QuotW:0] NegMax = 33'h0_8000_0000;

  assign cf  = ctl_q[QuotW];
  assign df  = d_q[QuotW];
  assign qrx = {1'b0, qx_q[QuotW]} + {32'b0, ({rx_q[QuotW], 1'b0} >= {1'b0, df})};
  assign qry = {1'b0, qy_q[QuotW]} + {32'b0, ({ry_q[QuotW], 1'b0} >= {1'b0, df})};
  assign sat_x = cf.ovf_x || (cf.neg_x ? (qrx > NegMax) : (qrx > PosMax));
  assign sat_y = cf.ovf_y || (cf.neg_y ? (qry > NegMax) : (qry > PosMax));
  assign vx = sat_x ? (cf.neg_x ? NegMax[QuotW-1:0] : PosMax[QuotW-1:0])
                    : (cf.neg_x ? -qrx[QuotW-1:0] : qrx[QuotW-1:0]);
  assign vy = sat_y ? (cf.neg_y ? NegMax[QuotW-1:0] : PosMax[QuotW-1:0])
                    : (cf.neg_y ? -qry[QuotW-1:0] : qry[QuotW-1:0]);

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= cf.valid;
  end

  always_ff @(posedge clk_i) begin
    out_x_o       <= cf.zero ? '0 : $signed(vx);
    out_y_o       <= cf.zero ? '0 : $signed(vy);
    zero_weight_o <= cf.zero;
    saturated_o   <= !cf.zero && (sat_x || sat_y);
  end

  assign done_o = done_q;

`ifndef ASSERT_OFF
  a_zero_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(zero_weight_o && saturated_o)) else $error("zero weight with saturation");
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_weight_o) |-> (out_x_o == '0 && out_y_o == '0))
    else $error("zero weight with nonzero result");
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |-> (out_x_o == 32'sh7FFF_FFFF || out_x_o == 32'sh8000_0000 ||
                                 out_y_o == 32'sh7FFF_FFFF || out_y_o == 32'sh8000_0000))
    else $error("saturation without clamped value");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q[0].valid) |-> ##(QuotW+1) done_o) else $error("item lost in divider chain");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the homography point map core: directed table and
// random points over several coefficient sets, each result checked in order against
// fixed expectations or a bit-exact predictor of the rounded, saturated quotients
// ----------------------------------------------------------------------------
module tb_top;
  import hpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic               zw;
    logic               sat;
  } map_res_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    bit          has_exp;
    map_res_t    exp_res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic signed [31:0] in_x_i = '0;
  logic signed [31:0] in_y_i = '0;
  logic cfg_ready_o, busy_o, done_o, zero_weight_o, saturated_o;
  logic signed [31:0] out_x_o, out_y_o;

  homography_point_map_core u_top (.*);

  initial forever #4 clk_i = ~clk_i;

  logic signed [31:0] coef [9];
  map_res_t pending_maps [$];
  int errors = 0;

  function automatic logic signed [31:0] round_div(logic signed [65:0] num,
      logic signed [65:0] den, inout logic sat);
    logic [81:0] n, d, q, r;
    logic neg;
    n = (num < 0) ? 82'(-num) : 82'(num);
    d = (den < 0) ? 82'(-den) : 82'(den);
    n = n << 16;
    neg = (num < 0) ^ (den < 0);
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    if (neg) begin
      if (q > 82'h80000000) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return -q[31:0];
    end
    if (q > 82'h7fffffff) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    return q[31:0];
  endfunction

  function automatic map_res_t map_point(logic signed [31:0] px, logic signed [31:0] py);
    logic signed [65:0] sx, sy, sw;
    map_res_t res;
    logic s;
    s = 1'b0;
    sx = 66'(px) * 66'(coef[0]) + 66'(py) * 66'(coef[3]) + (66'(coef[6]) <<< 16);
    sy = 66'(px) * 66'(coef[1]) + 66'(py) * 66'(coef[4]) + (66'(coef[7]) <<< 16);
    sw = 66'(px) * 66'(coef[2]) + 66'(py) * 66'(coef[5]) + (66'(coef[8]) <<< 16);
    if (sw == 0) begin
      res = '{ox: 0, oy: 0, zw: 1'b1, sat: 1'b0};
    end else begin
      res.ox = round_div(sx, sw, s);
      res.oy = round_div(sy, sw, s);
      res.zw = 1'b0;
      res.sat = s;
    end
    return res;
  endfunction

  task automatic write_coef(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegCoef0: begin coef[0] = data[31:0]; coef[1] = data[63:32]; end
      RegCoef1: begin coef[2] = data[31:0]; coef[3] = data[63:32]; end
      RegCoef2: begin coef[4] = data[31:0]; coef[5] = data[63:32]; end
      RegCoef3: begin coef[6] = data[31:0]; coef[7] = data[63:32]; end
      RegCoef4: coef[8] = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
      logic [63:0] w3, logic [63:0] w4);
    write_coef(RegCoef0, w0);
    write_coef(RegCoef1, w1);
    write_coef(RegCoef2, w2);
    write_coef(RegCoef3, w3);
    write_coef(RegCoef4, w4);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, bit has_exp, map_res_t exp_res);
    start_i <= 1'b1;
    in_x_i <= px;
    in_y_i <= py;
    do @(posedge clk_i); while (busy_o);
    pending_maps.push_back(has_exp ? exp_res : map_point(px, py));
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  // receiver side: results cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      map_res_t got, exp_r;
      got = '{ox: out_x_o, oy: out_y_o, zw: zero_weight_o, sat: saturated_o};
      if (pending_maps.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, got);
      end else begin
        exp_r = pending_maps.pop_front();
        if (got.ox !== exp_r.ox) begin
          errors++;
          $display("%0t out_x exp %h got %h", $time, exp_r.ox, got.ox);
        end
        if (got.oy !== exp_r.oy) begin
          errors++;
          $display("%0t out_y exp %h got %h", $time, exp_r.oy, got.oy);
        end
        if (got.zw !== exp_r.zw) begin
          errors++;
          $display("%0t zero_weight exp %b got %b", $time, exp_r.zw, got.zw);
        end
        if (got.sat !== exp_r.sat) begin
          errors++;
          $display("%0t saturated exp %b got %b", $time, exp_r.sat, got.sat);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    row_t dir [$];
    map_res_t none;
    int gap;
    none = '0;
    foreach (coef[i]) coef[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset all coefficients are zero: zero weight
    dir.push_back('{32'h7fffffff, 32'h80000000, 1, '{0, 0, 1, 0}});
    dir.push_back('{32'h0, 32'h0, 1, '{0, 0, 1, 0}});
    foreach (dir[i]) send_point(dir[i].px, dir[i].py, dir[i].has_exp, dir[i].exp_res);
    drain();

    // identity
    load_matrix({32'h0, 32'h00100000}, {32'h0, 32'h0}, {32'h0, 32'h00100000},
                64'h0, 64'hffffffff_00100000);
    dir.delete();
    dir.push_back('{32'h00010000, 32'h00020000, 1, '{32'h00010000, 32'h00020000, 0, 0}});
    dir.push_back('{32'h7fffffff, 32'h80000000, 1, '{32'h7fffffff, 32'h80000000, 0, 0}});
    dir.push_back('{32'h80000000, 32'h7fffffff, 1, '{32'h80000000, 32'h7fffffff, 0, 0}});
    dir.push_back('{32'hffffffff, 32'h00000001, 0, none});
    foreach (dir[i]) send_point(dir[i].px, dir[i].py, dir[i].has_exp, dir[i].exp_res);
    drain();

    // scale by 4, w constant: saturation both ways
    load_matrix({32'h0, 32'h00400000}, {32'h0, 32'h0}, {32'h0, 32'h00400000},
                64'h0, 64'h00100000);
    dir.delete();
    dir.push_back('{32'h7fffffff, 32'h80000000,
                    1, '{32'h7fffffff, 32'h80000000, 0, 1}});
    dir.push_back('{32'he0000000, 32'h00000000, 1, '{32'h80000000, 0, 0, 0}});
    dir.push_back('{32'h00000003, 32'hfffffffd, 0, none});
    foreach (dir[i]) send_point(dir[i].px, dir[i].py, dir[i].has_exp, dir[i].exp_res);
    drain();

    // extreme coefficients, weight from px and py; index out of range ignored
    load_matrix(64'h80000000_7fffffff, 64'h7fffffff_80000000, 64'h80000000_7fffffff,
                64'h7fffffff_80000000, 64'h80000001);
    write_coef(8'd5, 64'h12345678_9abcdef0);
    write_coef(8'hff, 64'hffffffff_ffffffff);
    dir.delete();
    dir.push_back('{32'h00000001, 32'h00000001, 0, none});
    dir.push_back('{32'h00000000, 32'h00000000, 0, none});
    dir.push_back('{32'h7fffffff, 32'h7fffffff, 0, none});
    dir.push_back('{32'h80000000, 32'h00000000, 0, none});
    dir.push_back('{32'h00010000, 32'hffff0000, 0, none});
    foreach (dir[i]) send_point(dir[i].px, dir[i].py, dir[i].has_exp, dir[i].exp_res);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      load_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                  {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                  {$urandom(), rand_coef()});
      for (int n = 0; n < 120; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 120; b++, n++)
          send_point(rand_coord(), rand_coord(), 0, none);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
